// ----- src/wrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared constants and register codes for the window range minimum unit.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 1024;
  localparam int unsigned DEF_MAX_ROWS    = 1024;
  localparam int unsigned DEF_MAX_WINDOW  = 32;
  localparam int unsigned DEF_PIXEL_BITS  = 16;

  localparam int unsigned CFG_DATA_BITS = 11;
  localparam int unsigned CFG_ADDR_BITS = 2;

  // register reset values
  localparam logic [CFG_DATA_BITS-1:0] RST_COLUMNS = 11'd1024;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROWS    = 11'd1024;
  localparam logic [CFG_DATA_BITS-1:0] RST_WINDOW  = 11'd2;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_WINDOW  = 2'd2
  } cfg_reg_e;

endpackage

// ----- src/window_range_minimum_unit.sv -----
// ----------------------------------------------------------------------------
// window_range_minimum_unit
// Smallest max-minus-min over all square windows of a raster frame.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and, with the frame's last pixel,
// emits the smallest range over all window_side x window_side windows plus a
// flag on tuser telling whether any window fit (if none, the range is all
// ones). The result is offered once the last pixel has passed the line buffer
// read, the range stage and the output register. A pixel is accepted every
// cycle; the input stalls only while a finished result still waits at the
// output and the next frame's result is already waiting behind it.
// Horizontal max/min comes from a row of MAX_WINDOW pixel cells, cell j
// holding max/min of the newest j+1 pixels. Vertical max/min comes from a row
// of MAX_WINDOW line buffer cells, cell j holding per column the max/min of
// the newest j+1 rows; each cell reads its line at the pixel's column and
// writes the merge with the new row value held in the stage-1 register.
// Registers take effect at once; zero is read as 1 and values above the
// parameter bounds as the bound.
// ----------------------------------------------------------------------------
module window_range_minimum_unit
  import wrm_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int unsigned PIXEL_BITS  = DEF_PIXEL_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0]        cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [PIXEL_BITS-1:0] pixel
  input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [PIXEL_BITS-1:0] min_range
  output logic [((PIXEL_BITS+7)/8)*8-1:0] m_axis_tdata,
  // [0] window_found
  output logic [0:0]                      m_axis_tuser
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned WW = $clog2(MAX_WINDOW);
  localparam int unsigned OW = ((PIXEL_BITS+7)/8)*8;
  localparam int unsigned MW = 2*PIXEL_BITS;

  // configuration
  logic [CFG_DATA_BITS-1:0] cols_q, rows_q, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= RST_COLUMNS;
      rows_q <= RST_ROWS;
      side_q <= RST_WINDOW;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_COLUMNS: cols_q <= cfg_data_i;
        REG_ROWS:    rows_q <= cfg_data_i;
        REG_WINDOW:  side_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] cols_w, rows_w, side_w;
  logic [WW-1:0] d_idx;

  assign cols_w = (cols_q == '0) ? 32'd1 :
                  (32'(cols_q) > MAX_COLUMNS) ? 32'(MAX_COLUMNS) : 32'(cols_q);
  assign rows_w = (rows_q == '0) ? 32'd1 :
                  (32'(rows_q) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(rows_q);
  assign side_w = (side_q == '0) ? 32'd1 :
                  (32'(side_q) > MAX_WINDOW) ? 32'(MAX_WINDOW) : 32'(side_q);
  assign d_idx  = WW'(side_w - 32'd1);

  // pipeline advance: the pipe moves unless a new result would have to
  // enter the output register while the previous one still waits there
  logic en, acc, out_busy;
  logic out_valid_q;
  logic s2_valid_q, s2_vvalid_q, s2_last_q;

  assign out_busy      = out_valid_q && !m_axis_tready;
  assign en            = !(out_busy && s2_valid_q && s2_last_q);
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  // stage 0: position counters, horizontal cells
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          col_end, row_end, hvalid, vvalid;
  logic [PIXEL_BITS-1:0] pix;

  assign pix     = s_axis_tdata[PIXEL_BITS-1:0];
  assign col_end = (32'(col_q) + 32'd1) >= cols_w;
  assign row_end = (32'(row_q) + 32'd1) >= rows_w;
  assign hvalid  = (32'(col_q) + 32'd1) >= side_w;
  assign vvalid  = hvalid && ((32'(row_q) + 32'd1) >= side_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  logic [MW-1:0] h_next [MAX_WINDOW];
  logic [MW-1:0] h_q    [MAX_WINDOW];

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_hcell
    wrm_hcell #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_hcell (
      .clk_i (clk_i),
      .en_i  (acc),
      .pix_i (pix),
      .prev_i((j == 0) ? {pix, pix} : h_q[(j == 0) ? 0 : j-1]),
      .next_o(h_next[j]),
      .q_o   (h_q[j])
    );
  end

  // stage 1: vertical cells
  logic          s1_valid_q, s1_vvalid_q, s1_last_q;
  logic [CW-1:0] s1_col_q;
  logic [MW-1:0] s1_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_h_q      <= h_next[d_idx];
      s1_col_q    <= col_q;
      s1_vvalid_q <= vvalid;
      s1_last_q   <= col_end && row_end;
    end
  end

  logic [MW-1:0] v_wd [MAX_WINDOW];
  logic [MW-1:0] v_rd [MAX_WINDOW];

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_vcell
    wrm_vcell #(
      .PIXEL_BITS (PIXEL_BITS),
      .MAX_COLUMNS(MAX_COLUMNS)
    ) u_vcell (
      .clk_i  (clk_i),
      .we_i   (s1_valid_q && en),
      .waddr_i(s1_col_q),
      .re_i   (en),
      .raddr_i(col_q),
      .h_i    (s1_h_q),
      .prev_i ((j == 0) ? s1_h_q : v_rd[(j == 0) ? 0 : j-1]),
      .wd_o   (v_wd[j]),
      .rd_o   (v_rd[j])
    );
  end

  // stage 2: range and running minimum
  logic [PIXEL_BITS-1:0] s2_max_q, s2_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      {s2_max_q, s2_min_q} <= v_wd[d_idx];
      s2_vvalid_q          <= s1_vvalid_q;
      s2_last_q            <= s1_last_q;
    end
  end

  logic [PIXEL_BITS-1:0] range, best_q, best_d;
  logic                  any_q, any_d;

  assign range  = (s2_max_q >= s2_min_q) ? s2_max_q - s2_min_q : '0;
  assign best_d = (s2_vvalid_q && (range < best_q)) ? range : best_q;
  assign any_d  = any_q || s2_vvalid_q;

  logic [PIXEL_BITS-1:0] out_range_q;
  logic                  out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '1;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en && s2_valid_q) begin
        // update the running minimum; at frame end hand out and restart it
        best_q <= s2_last_q ? '1 : best_d;
        any_q  <= s2_last_q ? 1'b0 : any_d;
      end
      // output register holds while its result waits
      if (!out_busy) begin
        out_valid_q <= s2_valid_q && s2_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_busy) begin
      out_range_q <= best_d;
      out_found_q <= any_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OW'(out_range_q);
  assign m_axis_tuser  = out_found_q;

endmodule

// ----- src/wrm_ram.sv -----
// ----------------------------------------------------------------------------
// wrm_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module wrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      // same-cycle write to the read address returns the new word
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/wrm_hcell.sv -----
// ----------------------------------------------------------------------------
// wrm_hcell
// Horizontal cell: max/min over its own depth of the newest pixels.
// ----------------------------------------------------------------------------
module wrm_hcell #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [PIXEL_BITS-1:0]   pix_i,
  input  logic [2*PIXEL_BITS-1:0] prev_i,  // {max, min} of upstream cell
  output logic [2*PIXEL_BITS-1:0] next_o,  // value taken at this transfer
  output logic [2*PIXEL_BITS-1:0] q_o
);

  logic [PIXEL_BITS-1:0]   pmax, pmin, nmax, nmin;
  logic [2*PIXEL_BITS-1:0] mm_q;

  assign pmax = prev_i[2*PIXEL_BITS-1:PIXEL_BITS];
  assign pmin = prev_i[PIXEL_BITS-1:0];
  assign nmax = (pix_i > pmax) ? pix_i : pmax;
  assign nmin = (pix_i < pmin) ? pix_i : pmin;
  assign next_o = {nmax, nmin};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mm_q <= next_o;
    end
  end

  assign q_o = mm_q;

endmodule

// ----- src/wrm_vcell.sv -----
// ----------------------------------------------------------------------------
// wrm_vcell
// Vertical cell: line buffer of per-column max/min over its depth of rows.
// ----------------------------------------------------------------------------
module wrm_vcell #(
  parameter int unsigned PIXEL_BITS  = 16,
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(MAX_COLUMNS)-1:0] waddr_i,
  input  logic                           re_i,
  input  logic [$clog2(MAX_COLUMNS)-1:0] raddr_i,
  input  logic [2*PIXEL_BITS-1:0]        h_i,     // row max/min of this column
  input  logic [2*PIXEL_BITS-1:0]        prev_i,  // upstream cell, previous row
  output logic [2*PIXEL_BITS-1:0]        wd_o,
  output logic [2*PIXEL_BITS-1:0]        rd_o
);

  logic [PIXEL_BITS-1:0] hmax, hmin, pmax, pmin;

  assign hmax = h_i[2*PIXEL_BITS-1:PIXEL_BITS];
  assign hmin = h_i[PIXEL_BITS-1:0];
  assign pmax = prev_i[2*PIXEL_BITS-1:PIXEL_BITS];
  assign pmin = prev_i[PIXEL_BITS-1:0];
  assign wd_o = {(hmax > pmax) ? hmax : pmax, (hmin < pmin) ? hmin : pmin};

  wrm_ram #(
    .WIDTH(2*PIXEL_BITS),
    .DEPTH(MAX_COLUMNS)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wd_o),
    .re_i   (re_i),
    .raddr_i(raddr_i),
    .rdata_o(rd_o)
  );

endmodule
